### rtl/shortest_edit_script_defines.svh
// Assertion macros for the shortest edit script block.
// Used by the checker module; no other dependencies.
`ifndef SHORTEST_EDIT_SCRIPT_DEFINES_SVH
`define SHORTEST_EDIT_SCRIPT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SES_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Implication checked on every clock edge, reset included.
`define SES_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`endif

### rtl/ses_pkg.sv
// Package for the shortest edit script block: sizes, codes and transaction types.
// No dependencies.
package ses_pkg;
   localparam int MAX_LEN     = 16;
   localparam int SYMBOL_BITS = 8;
   localparam int LEN_BITS    = 5;
   localparam int IDX_BITS    = 4;
   localparam int POS_BITS    = 6;
   localparam int SPAN        = 4 * MAX_LEN + 3;
   localparam int CENTER      = 2 * MAX_LEN + 1;
   localparam int ROUNDS      = 2 * MAX_LEN + 1;
   localparam int SCRIPT_DEPTH = 2 * MAX_LEN;
   localparam int K_BITS      = 8;   // signed diagonal index
   localparam int FA_BITS     = 7;   // frontier address
   localparam int SA_BITS     = 12;  // snapshot address
   localparam int D_BITS      = 6;
   localparam int CNT_BITS    = 6;

   localparam logic [1:0] OP_APPEND_OLD = 2'd0;
   localparam logic [1:0] OP_APPEND_NEW = 2'd1;
   localparam logic [1:0] OP_COMPUTE    = 2'd2;

   localparam logic [1:0] EDIT_EQUAL  = 2'd0;
   localparam logic [1:0] EDIT_DELETE = 2'd1;
   localparam logic [1:0] EDIT_INSERT = 2'd2;
   localparam logic [1:0] EDIT_END    = 2'd3;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] symbol;
   } req_type;

   typedef struct packed {
      logic [1:0] edit_kind;
      logic [3:0] old_index;
      logic [3:0] new_index;
      logic [5:0] edit_distance;
      logic       overflow;
      logic       last;
   } rsp_type;
endpackage

### rtl/shortest_edit_script.sv
// Shortest edit script (greedy Myers diff): top level, sequencer and memories; uses ses_pkg.
// Appends: accepted back to back while idle. Compute: clears the frontier, then per round
// snapshots it and per diagonal reads both neighbours, picks the start, follows the snake
// and writes the reach. Backtrack: per round reads the snapshot and records edits; then
// one result per cycle, end marker last, then busy drops. Receiver cannot stall.
// Reset (synchronous, active high) clears lengths, overflow flag and the sequencer.
module shortest_edit_script (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ses_pkg::req_type req_data,
   output logic             rsp_strobe,
   output ses_pkg::rsp_type rsp_data
);
   typedef enum logic [17:0] {
      S_IDLE  = 18'h00001, S_CLR   = 18'h00002, S_SNAP  = 18'h00004,
      S_KRD1  = 18'h00008, S_KRD2  = 18'h00010, S_KCALC = 18'h00020,
      S_SNAKE = 18'h00040, S_KWR   = 18'h00080, S_BRD1  = 18'h00100,
      S_BRD2  = 18'h00200, S_BRD3  = 18'h00400, S_BSEL  = 18'h00800,
      S_BPX   = 18'h01000, S_BDIAG = 18'h02000, S_BSTEP = 18'h04000,
      S_EMIT  = 18'h08000, S_EMITW = 18'h10000, S_END   = 18'h20000
   } state_type;

   state_type state_ff, state_in;

   // Stores
   logic [ses_pkg::SYMBOL_BITS-1:0] old_mem [ses_pkg::MAX_LEN];
   logic [ses_pkg::SYMBOL_BITS-1:0] new_mem [ses_pkg::MAX_LEN];
   logic [ses_pkg::POS_BITS-1:0] front_mem [ses_pkg::SPAN];
   logic [ses_pkg::POS_BITS-1:0] snap_mem [ses_pkg::ROUNDS*ses_pkg::SPAN];
   logic [11:0] script_mem [ses_pkg::SCRIPT_DEPTH];

   logic [ses_pkg::LEN_BITS-1:0] old_len_ff, new_len_ff;
   logic dropped_ff;

   // Working registers
   logic [ses_pkg::D_BITS-1:0] d_ff, d_in;
   logic signed [ses_pkg::K_BITS-1:0] k_ff, k_in;
   logic [ses_pkg::FA_BITS-1:0] idx_ff, idx_in;
   logic [ses_pkg::POS_BITS-1:0] a_ff, a_in, b_ff, b_in;
   logic signed [ses_pkg::K_BITS-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ses_pkg::K_BITS-1:0] px_ff, px_in, pk_ff, pk_in;
   logic [ses_pkg::D_BITS-1:0] dist_ff, dist_in;
   logic [ses_pkg::CNT_BITS-1:0] cnt_ff, cnt_in;
   logic snake_rd_ff, snake_rd_in;

   // Memory read ports (registered)
   logic [ses_pkg::FA_BITS-1:0] f_raddr;
   logic [ses_pkg::POS_BITS-1:0] f_rdata_ff;
   logic [ses_pkg::SA_BITS-1:0] s_raddr;
   logic [ses_pkg::POS_BITS-1:0] s_rdata_ff;
   logic [ses_pkg::IDX_BITS-1:0] o_raddr, n_raddr;
   logic [ses_pkg::SYMBOL_BITS-1:0] o_rdata_ff, n_rdata_ff;
   logic [ses_pkg::CNT_BITS-2:0] b_raddr;
   logic [11:0] b_rdata_ff;
   logic f_we, s_we, b_we;
   logic [ses_pkg::FA_BITS-1:0] f_waddr;
   logic [ses_pkg::POS_BITS-1:0] f_wdata;
   logic [ses_pkg::SA_BITS-1:0] s_waddr;
   logic [11:0] b_wdata;

   logic signed [ses_pkg::K_BITS-1:0] n_s, m_s, d_s;
   logic accept;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;
   assign n_s = ses_pkg::K_BITS'(old_len_ff);
   assign m_s = ses_pkg::K_BITS'(new_len_ff);
   assign d_s = ses_pkg::K_BITS'(d_ff);

   // Frontier address of diagonal k; out-of-span reads as zero
   function automatic logic in_span(input logic signed [ses_pkg::K_BITS-1:0] k);
      logic signed [ses_pkg::K_BITS:0] i;
      i = ($signed({k[ses_pkg::K_BITS-1], k}) + (ses_pkg::K_BITS+1)'(ses_pkg::CENTER));
      return (i >= 0) && (i < (ses_pkg::K_BITS+1)'(ses_pkg::SPAN));
   endfunction
   function automatic logic [ses_pkg::FA_BITS-1:0] faddr(
         input logic signed [ses_pkg::K_BITS-1:0] k);
      return ses_pkg::FA_BITS'(k + ses_pkg::K_BITS'(ses_pkg::CENTER));
   endfunction

   // Appends and lengths
   always_ff @(posedge clock) begin
      if (reset) begin
         old_len_ff <= '0;
         new_len_ff <= '0;
         dropped_ff <= 1'b0;
      end else if (accept) begin
         if (req_data.operation == ses_pkg::OP_APPEND_OLD) begin
            if (old_len_ff < ses_pkg::LEN_BITS'(ses_pkg::MAX_LEN)) begin
               old_len_ff <= old_len_ff + 1'b1;
            end else begin
               dropped_ff <= 1'b1;
            end
         end else if (req_data.operation == ses_pkg::OP_APPEND_NEW) begin
            if (new_len_ff < ses_pkg::LEN_BITS'(ses_pkg::MAX_LEN)) begin
               new_len_ff <= new_len_ff + 1'b1;
            end else begin
               dropped_ff <= 1'b1;
            end
         end
      end
   end

   // Symbol stores
   always_ff @(posedge clock) begin
      if (accept && req_data.operation == ses_pkg::OP_APPEND_OLD &&
          old_len_ff < ses_pkg::LEN_BITS'(ses_pkg::MAX_LEN)) begin
         old_mem[old_len_ff[ses_pkg::IDX_BITS-1:0]] <= req_data.symbol;
      end
      if (accept && req_data.operation == ses_pkg::OP_APPEND_NEW &&
          new_len_ff < ses_pkg::LEN_BITS'(ses_pkg::MAX_LEN)) begin
         new_mem[new_len_ff[ses_pkg::IDX_BITS-1:0]] <= req_data.symbol;
      end
      o_rdata_ff <= old_mem[o_raddr];
      n_rdata_ff <= new_mem[n_raddr];
   end

   // Frontier, snapshot and script memories
   always_ff @(posedge clock) begin
      if (f_we) begin
         front_mem[f_waddr] <= f_wdata;
      end
      f_rdata_ff <= front_mem[f_raddr];
      if (s_we) begin
         snap_mem[s_waddr] <= f_rdata_ff;
      end
      s_rdata_ff <= snap_mem[s_raddr];
      if (b_we) begin
         script_mem[cnt_ff[ses_pkg::CNT_BITS-2:0]] <= b_wdata;
      end
      b_rdata_ff <= script_mem[b_raddr];
   end

   // Sequencer
   always_comb begin
      logic signed [ses_pkg::K_BITS-1:0] kk, xx, yy;
      logic signed [ses_pkg::K_BITS-1:0] va, vb;
      logic take_up;
      state_in = state_ff;
      d_in = d_ff; k_in = k_ff; idx_in = idx_ff; a_in = a_ff; b_in = b_ff;
      x_in = x_ff; y_in = y_ff; px_in = px_ff; pk_in = pk_ff;
      dist_in = dist_ff; cnt_in = cnt_ff; snake_rd_in = 1'b0;
      f_raddr = idx_ff; s_raddr = '0;
      o_raddr = x_ff[ses_pkg::IDX_BITS-1:0];
      n_raddr = y_ff[ses_pkg::IDX_BITS-1:0];
      b_raddr = '0;
      f_we = 1'b0; f_waddr = idx_ff; f_wdata = '0;
      s_we = 1'b0; s_waddr = '0;
      b_we = 1'b0; b_wdata = '0;
      rsp_strobe = 1'b0;
      rsp_data = '0;
      kk = '0; xx = '0; yy = '0;
      va = ses_pkg::K_BITS'(a_ff); vb = ses_pkg::K_BITS'(b_ff);
      take_up = 1'b0;
      case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            if (accept && req_data.operation == ses_pkg::OP_COMPUTE) begin
               state_in = S_CLR;
            end
         end
         S_CLR: begin
            f_we = 1'b1; f_waddr = idx_ff;
            if (idx_ff == ses_pkg::FA_BITS'(ses_pkg::SPAN - 1)) begin
               idx_in = '0; d_in = '0; state_in = S_SNAP;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         // Copy frontier into snapshot d: read idx, write idx-1 in the next cycle
         S_SNAP: begin
            f_raddr = idx_ff;
            s_we = (idx_ff != '0);
            s_waddr = ses_pkg::SA_BITS'(d_ff * ses_pkg::SPAN)
                      + ses_pkg::SA_BITS'(idx_ff) - 1'b1;
            if (idx_ff == ses_pkg::FA_BITS'(ses_pkg::SPAN)) begin
               k_in = -d_s; state_in = S_KRD1;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_KRD1: begin
            f_raddr = faddr(k_ff - 1'b1);
            state_in = S_KRD2;
         end
         S_KRD2: begin
            a_in = in_span(k_ff - 1'b1) ? f_rdata_ff : '0;
            f_raddr = faddr(k_ff + 1'b1);
            state_in = S_KCALC;
         end
         S_KCALC: begin
            vb = in_span(k_ff + 1'b1) ? ses_pkg::K_BITS'(f_rdata_ff) : '0;
            take_up = (k_ff == -d_s) || ((k_ff != d_s) && (va < vb));
            xx = take_up ? vb : va + ses_pkg::K_BITS'(1);
            x_in = xx; y_in = xx - k_ff;
            state_in = S_SNAKE;
         end
         // Snake: issue symbol read, then compare next cycle
         S_SNAKE: begin
            if (!snake_rd_ff) begin
               if (x_ff >= 0 && y_ff >= 0 && x_ff < n_s && y_ff < m_s) begin
                  snake_rd_in = 1'b1;
               end else begin
                  state_in = S_KWR;
               end
            end else if (o_rdata_ff == n_rdata_ff) begin
               x_in = x_ff + 1'b1; y_in = y_ff + 1'b1;
            end else begin
               state_in = S_KWR;
            end
         end
         S_KWR: begin
            f_we = in_span(k_ff); f_waddr = faddr(k_ff);
            f_wdata = ses_pkg::POS_BITS'(x_ff);
            if (x_ff >= n_s && y_ff >= m_s) begin
               dist_in = d_ff; state_in = S_BRD1;
            end else if (k_ff == d_s) begin
               if (d_s + 1'b1 > n_s + m_s ||
                   d_ff == ses_pkg::D_BITS'(ses_pkg::ROUNDS - 1)) begin
                  dist_in = ses_pkg::D_BITS'(n_s + m_s); state_in = S_BRD1;
               end else begin
                  d_in = d_ff + 1'b1; idx_in = '0; state_in = S_SNAP;
               end
            end else begin
               k_in = k_ff + ses_pkg::K_BITS'(2); state_in = S_KRD1;
            end
            if (state_in == S_BRD1) begin
               d_in = dist_in; x_in = n_s; y_in = m_s; cnt_in = '0;
            end
         end
         // Backtrack: read v[k-1], v[k+1] of snapshot d
         S_BRD1: begin
            kk = x_ff - y_ff; k_in = kk;
            s_raddr = ses_pkg::SA_BITS'(d_ff * ses_pkg::SPAN)
                      + ses_pkg::SA_BITS'(faddr(kk - 1'b1));
            state_in = S_BRD2;
         end
         S_BRD2: begin
            a_in = in_span(k_ff - 1'b1) ? s_rdata_ff : '0;
            s_raddr = ses_pkg::SA_BITS'(d_ff * ses_pkg::SPAN)
                      + ses_pkg::SA_BITS'(faddr(k_ff + 1'b1));
            state_in = S_BRD3;
         end
         S_BRD3: begin
            b_in = in_span(k_ff + 1'b1) ? s_rdata_ff : '0;
            state_in = S_BSEL;
         end
         S_BSEL: begin
            take_up = (k_ff == -d_s) || ((k_ff != d_s) && (va < vb));
            pk_in = take_up ? k_ff + 1'b1 : k_ff - 1'b1;
            px_in = take_up ? vb : va;
            if (!in_span(pk_in)) px_in = '0;
            state_in = S_BDIAG;
         end
         S_BDIAG: begin
            yy = px_ff - pk_ff;
            if (x_ff > px_ff && y_ff > yy &&
                cnt_ff < ses_pkg::CNT_BITS'(ses_pkg::SCRIPT_DEPTH)) begin
               b_we = 1'b1;
               b_wdata = {ses_pkg::EDIT_EQUAL, 2'b00,
                          ses_pkg::IDX_BITS'(x_ff - 1'b1),
                          ses_pkg::IDX_BITS'(y_ff - 1'b1)};
               cnt_in = cnt_ff + 1'b1;
               x_in = x_ff - 1'b1; y_in = y_ff - 1'b1;
            end else begin
               state_in = S_BSTEP;
            end
         end
         S_BSTEP: begin
            yy = px_ff - pk_ff;
            if (d_ff != '0 && cnt_ff < ses_pkg::CNT_BITS'(ses_pkg::SCRIPT_DEPTH)) begin
               if (x_ff == px_ff) begin
                  b_we = 1'b1;
                  b_wdata = {ses_pkg::EDIT_INSERT, 2'b00, 4'd0,
                             ses_pkg::IDX_BITS'(yy)};
                  cnt_in = cnt_ff + 1'b1;
               end else if (y_ff == yy) begin
                  b_we = 1'b1;
                  b_wdata = {ses_pkg::EDIT_DELETE, 2'b00,
                             ses_pkg::IDX_BITS'(px_ff), 4'd0};
                  cnt_in = cnt_ff + 1'b1;
               end
            end
            x_in = px_ff; y_in = yy;
            if (d_ff == '0) begin
               state_in = S_EMIT;
            end else begin
               d_in = d_ff - 1'b1; state_in = S_BRD1;
            end
         end
         // Emit script in reverse buffer order
         S_EMIT: begin
            if (cnt_ff == '0) begin
               state_in = S_END;
            end else begin
               b_raddr = (ses_pkg::CNT_BITS-1)'(cnt_ff - 1'b1);
               cnt_in = cnt_ff - 1'b1;
               state_in = S_EMITW;
            end
         end
         S_EMITW: begin
            rsp_strobe = 1'b1;
            rsp_data.edit_kind = b_rdata_ff[11:10];
            rsp_data.old_index = b_rdata_ff[7:4];
            rsp_data.new_index = b_rdata_ff[3:0];
            rsp_data.overflow  = dropped_ff;
            b_raddr = (ses_pkg::CNT_BITS-1)'(cnt_ff - 1'b1);
            if (cnt_ff == '0) begin
               state_in = S_END;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         S_END: begin
            rsp_strobe = 1'b1;
            rsp_data.edit_kind = ses_pkg::EDIT_END;
            rsp_data.edit_distance = dist_ff;
            rsp_data.overflow = dropped_ff;
            rsp_data.last = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
      if (snake_rd_in) begin
         o_raddr = x_ff[ses_pkg::IDX_BITS-1:0];
         n_raddr = y_ff[ses_pkg::IDX_BITS-1:0];
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         snake_rd_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         snake_rd_ff <= snake_rd_in;
      end
      d_ff <= d_in; k_ff <= k_in; idx_ff <= idx_in; a_ff <= a_in; b_ff <= b_in;
      x_ff <= x_in; y_ff <= y_in; px_ff <= px_in; pk_ff <= pk_in;
      dist_ff <= dist_in; cnt_ff <= cnt_in;
   end
endmodule

### rtl/ses_checker.sv
// Port-level checker for the shortest edit script block, bound to the top level.
// Depends on ses_pkg and shortest_edit_script_defines.svh.
`include "shortest_edit_script_defines.svh"
module ses_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input ses_pkg::req_type req_data,
   input logic             rsp_strobe,
   input ses_pkg::rsp_type rsp_data
);
   // End marker closes the transaction and frees the block
   `SES_ASSERT(a_end_idle, clock, reset, rsp_strobe && rsp_data.last |=> !busy, "busy after end")
   // Results only while busy
   `SES_ASSERT(a_rsp_busy, clock, reset, rsp_strobe |-> busy, "result while idle")
   // last only on end marker
   `SES_ASSERT(a_last_kind, clock, reset, rsp_strobe && rsp_data.last |-> rsp_data.edit_kind == ses_pkg::EDIT_END, "last on edit")
   // Reset leaves the block idle
   `SES_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !busy, "busy after reset")
endmodule

bind shortest_edit_script ses_checker u_ses_checker (.*);

### tb/tb_shortest_edit_script.sv
// Self-checking testbench for shortest_edit_script: appends, compute requests,
// edit script and end marker checked against an in-bench diff predictor.
// Depends on ses_pkg and the shortest_edit_script RTL.
module tb_shortest_edit_script;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] OP_UNUSED = 2'd3;

   // Diff predictor plus queue of expected edit transactions
   class edit_scoreboard;
      logic [7:0]       old_seq[ses_pkg::MAX_LEN];
      logic [7:0]       new_seq[ses_pkg::MAX_LEN];
      int               old_len;
      int               new_len;
      bit               dropped;
      int               reach[ses_pkg::SPAN];
      int               snap[ses_pkg::ROUNDS][ses_pkg::SPAN];
      ses_pkg::rsp_type pending[$];
      int               mismatches;
      int               edits_seen;
      int               computes;
      int               max_dist;

      function int reach_at(int k, int r);
         int i;
         i = ses_pkg::CENTER + k;
         if (i < 0 || i >= ses_pkg::SPAN) return 0;
         return (r < 0) ? reach[i] : snap[r][i];
      endfunction

      function void set_reach(int k, int val);
         int i;
         i = ses_pkg::CENTER + k;
         if (i >= 0 && i < ses_pkg::SPAN) reach[i] = val;
      endfunction

      // Greedy forward search; returns edit distance
      function int find_distance();
         int x, y;
         for (int i = 0; i < ses_pkg::SPAN; i++) reach[i] = 0;
         for (int d = 0; d <= old_len + new_len && d < ses_pkg::ROUNDS; d++) begin
            snap[d] = reach;
            for (int k = -d; k <= d; k += 2) begin
               if (k == -d || (k != d && reach_at(k - 1, -1) < reach_at(k + 1, -1)))
                  x = reach_at(k + 1, -1);
               else
                  x = reach_at(k - 1, -1) + 1;
               y = x - k;
               while (x >= 0 && y >= 0 && x < old_len && y < new_len &&
                      old_seq[x] == new_seq[y]) begin
                  x++;
                  y++;
               end
               set_reach(k, x);
               if (x >= old_len && y >= new_len) return d;
            end
         end
         return old_len + new_len;
      endfunction

      function void note(ses_pkg::req_type req);
         ses_pkg::rsp_type script[$];
         ses_pkg::rsp_type e;
         int edit_dist, x, y, k, pk, px, py;
         case (req.operation)
            ses_pkg::OP_APPEND_OLD: begin
               if (old_len < ses_pkg::MAX_LEN) old_seq[old_len++] = req.symbol;
               else dropped = 1'b1;
            end
            ses_pkg::OP_APPEND_NEW: begin
               if (new_len < ses_pkg::MAX_LEN) new_seq[new_len++] = req.symbol;
               else dropped = 1'b1;
            end
            ses_pkg::OP_COMPUTE: begin
               computes++;
               edit_dist = find_distance();
               if (edit_dist > max_dist) max_dist = edit_dist;
               x = old_len;
               y = new_len;
               // backtrack, collecting edits last-first
               for (int d = edit_dist; d >= 0; d--) begin
                  k = x - y;
                  if (k == -d || (k != d && reach_at(k - 1, d) < reach_at(k + 1, d)))
                     pk = k + 1;
                  else
                     pk = k - 1;
                  px = reach_at(pk, d);
                  py = px - pk;
                  while (x > px && y > py && script.size() < ses_pkg::SCRIPT_DEPTH) begin
                     e = '0;
                     e.edit_kind = ses_pkg::EDIT_EQUAL;
                     e.old_index = 4'(x - 1);
                     e.new_index = 4'(y - 1);
                     script.push_front(e);
                     x--;
                     y--;
                  end
                  if (d > 0 && script.size() < ses_pkg::SCRIPT_DEPTH) begin
                     e = '0;
                     if (x == px) begin
                        e.edit_kind = ses_pkg::EDIT_INSERT;
                        e.new_index = 4'(py);
                        script.push_front(e);
                     end else if (y == py) begin
                        e.edit_kind = ses_pkg::EDIT_DELETE;
                        e.old_index = 4'(px);
                        script.push_front(e);
                     end
                  end
                  x = px;
                  y = py;
               end
               foreach (script[i]) begin
                  script[i].overflow = dropped;
                  pending = {pending, script[i]};
               end
               e = '0;
               e.edit_kind     = ses_pkg::EDIT_END;
               e.edit_distance = 6'(edit_dist);
               e.overflow      = dropped;
               e.last          = 1'b1;
               pending = {pending, e};
            end
            default: ;
         endcase
      endfunction

      function void flag(string what, ses_pkg::rsp_type exp_t, ses_pkg::rsp_type got);
         mismatches++;
         if (mismatches <= 10)
            $display("MISMATCH %s: expected %p, got %p", what, exp_t, got);
      endfunction

      function void check(ses_pkg::rsp_type got);
         ses_pkg::rsp_type exp_t;
         edits_seen++;
         if (pending.size() == 0) begin
            flag("unexpected edit transaction", '0, got);
            return;
         end
         exp_t = pending.pop_front();
         if (got.edit_kind != exp_t.edit_kind) flag("edit_kind", exp_t, got);
         if (got.old_index != exp_t.old_index) flag("old_index", exp_t, got);
         if (got.new_index != exp_t.new_index) flag("new_index", exp_t, got);
         if (got.edit_distance != exp_t.edit_distance) flag("edit_distance", exp_t, got);
         if (got.overflow != exp_t.overflow) flag("overflow", exp_t, got);
         if (got.last != exp_t.last) flag("last", exp_t, got);
      endfunction
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             start = 1'b0;
   logic             busy;
   ses_pkg::req_type req_data = '0;
   logic             rsp_strobe;
   ses_pkg::rsp_type rsp_data;

   edit_scoreboard diff_sb = new();

   shortest_edit_script uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Result monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) diff_sb.check(rsp_data);
   end

   // Watchdog
   initial begin
      #20ms;
      $display("timeout, %0d transactions still expected", diff_sb.pending.size());
      $display("tb_shortest_edit_script: done, errors");
      $finish;
   end

   bit allow_gaps = 1'b1;

   task automatic send(logic [1:0] op, logic [7:0] sym);
      ses_pkg::req_type r;
      r.operation = op;
      r.symbol    = sym;
      @(negedge clock);
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      diff_sb.note(r);
      if (allow_gaps && $urandom_range(0, 3) == 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat ($urandom_range(0, 2)) @(negedge clock);
      end
   endtask

   // Hold off until every expected edit has arrived
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (diff_sb.pending.size() != 0) @(posedge clock);
   endtask

   // Mostly a small alphabet so that equal runs occur
   function automatic logic [7:0] pick_symbol();
      return ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
   endfunction

   initial begin
      int total;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: empty compute, deletes only, inserts, extremes, unused code
      send(ses_pkg::OP_COMPUTE, 8'h00);
      send(ses_pkg::OP_APPEND_OLD, 8'h00);
      send(ses_pkg::OP_APPEND_OLD, 8'hFF);
      send(ses_pkg::OP_COMPUTE, 8'h00);
      send(ses_pkg::OP_APPEND_NEW, 8'hFF);
      send(ses_pkg::OP_APPEND_NEW, 8'hAA);
      send(ses_pkg::OP_APPEND_NEW, 8'h55);
      send(ses_pkg::OP_COMPUTE, 8'hFF);
      send(OP_UNUSED, 8'h12);
      send(ses_pkg::OP_APPEND_OLD, 8'h55);
      send(ses_pkg::OP_COMPUTE, 8'h00);
      drain();

      // Random: appends interleaved with computes; fills to the limit, then drops
      total = 430;
      for (int n = 0; n < total; n++) begin
         int sel;
         if (n == total - 60) allow_gaps = 1'b0;
         if (n == 200) drain();
         sel = $urandom_range(0, 99);
         if (sel < 14) send(ses_pkg::OP_COMPUTE, 8'($urandom));
         else if (sel < 16) send(OP_UNUSED, 8'($urandom));
         else if (sel < 58) send(ses_pkg::OP_APPEND_OLD, pick_symbol());
         else send(ses_pkg::OP_APPEND_NEW, pick_symbol());
      end
      send(ses_pkg::OP_COMPUTE, 8'h00);
      @(negedge clock);
      start <= 1'b0;
      while (diff_sb.pending.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);

      $display("covered %0d compute requests, %0d edit transactions, largest distance %0d",
               diff_sb.computes, diff_sb.edits_seen, diff_sb.max_dist);
      $display("final lengths old %0d new %0d, overflow %0d, mismatches %0d",
               diff_sb.old_len, diff_sb.new_len, diff_sb.dropped, diff_sb.mismatches);
      if (diff_sb.mismatches == 0 && diff_sb.pending.size() == 0)
         $display("tb_shortest_edit_script: done, clean");
      else
         $display("tb_shortest_edit_script: done, errors");
      $finish;
   end
endmodule
